### src/nps_pkg.sv
// Types and constants shared by the priority scheduler modules.
// No dependencies.
package nps_pkg;
   localparam int unsigned ARR_W  = 16;
   localparam int unsigned BUR_W  = 16;
   localparam int unsigned PRI_W  = 8;
   localparam int unsigned TIME_W = 21;
   localparam int unsigned NUM_W  = 7;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [ARR_W-1:0] arrival;
      logic [BUR_W-1:0] burst;
      logic [PRI_W-1:0] prio;
      logic [NUM_W-1:0] num;
   } job_type;

   // Candidate token that walks down the cell row.
   typedef struct packed {
      logic             found;
      logic [ARR_W-1:0] arrival;
      logic [PRI_W-1:0] prio;
      logic [BUR_W-1:0] burst;
      logic [NUM_W-1:0] num;
      logic             have_next;
      logic [ARR_W-1:0] next_arr;
   } cand_type;
endpackage

### src/nps_cell.sv
// One job slot of the scheduler row: holds a job, compares it with the
// passing candidate and hands the better one on, registered, to the next
// cell. Uses nps_pkg.
module nps_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  nps_pkg::job_type   load_job,
   input  logic               clear,
   input  logic               mark,
   input  logic [6:0]         mark_num,
   input  logic [20:0]        now,
   input  logic               hi_first,
   input  nps_pkg::cand_type  cand_i,
   output nps_pkg::cand_type  cand_o
);
   import nps_pkg::*;

   job_type  job_ff;
   logic     used_ff;
   logic     done_ff;
   logic     ready;
   logic     wins;
   cand_type cand_in, cand_ff;

   always_ff @(posedge clock) begin
      if (load) job_ff <= load_job;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         used_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (load) used_ff <= 1'b1;
         if (mark && used_ff && job_ff.num == mark_num) done_ff <= 1'b1;
      end
   end

   assign ready = used_ff && !done_ff && ({5'd0, job_ff.arrival} <= now);

   always_comb begin
      wins = 1'b0;
      if (!cand_i.found) wins = 1'b1;
      else if (job_ff.prio != cand_i.prio)
         wins = hi_first ? (job_ff.prio > cand_i.prio) : (job_ff.prio < cand_i.prio);
      else wins = job_ff.arrival < cand_i.arrival;
   end

   always_comb begin
      cand_in = cand_i;
      if (ready && wins) begin
         cand_in.found   = 1'b1;
         cand_in.arrival = job_ff.arrival;
         cand_in.prio    = job_ff.prio;
         cand_in.burst   = job_ff.burst;
         cand_in.num     = job_ff.num;
      end
      if (used_ff && !done_ff &&
          (!cand_i.have_next || job_ff.arrival < cand_i.next_arr)) begin
         cand_in.have_next = 1'b1;
         cand_in.next_arr  = job_ff.arrival;
      end
   end

   // Advance the candidate one cell per cycle.
   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   assign cand_o = cand_ff;
endmodule

### src/nonpreemptive_priority_scheduler.sv
// Top level of the non-preemptive priority scheduler: load control, cell
// row, pick sequencer and result register. Uses nps_pkg and nps_cell.
//
// Jobs load one beat per cycle while busy is low. The beat with
// last_process set loads its job and raises busy; the block then makes
// one pick per pass over the cell row. The candidate token moves one cell
// per cycle; one extra pass is made when no unfinished job has arrived
// and time jumps ahead, and each pick ends in the emit state. Each result
// shows on rsp_* for one cycle with rsp_valid high; the receiver cannot
// hold it off. A job that comes when all MAX_PROCS slots are full is
// dropped. Time saturates at 2^21-1 and waiting time is clamped at zero.
module nonpreemptive_priority_scheduler #(
   parameter int unsigned MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_time,
   input  logic [7:0]  req_priority_req,
   input  logic        req_last_process,
   output logic        rsp_valid,
   output logic [6:0]  rsp_process_number,
   output logic [20:0] rsp_completion_time,
   output logic [20:0] rsp_turnaround_time,
   output logic [20:0] rsp_waiting_time,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_high_number_first
);
   import nps_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_PICK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic        hi_ff;
   logic [6:0]  count_ff, count_in;
   logic [6:0]  left_ff, left_in;
   logic [6:0]  walk_ff, walk_in;
   logic [20:0] now_ff, now_in;
   cand_type    chain [MAX_PROCS+1];
   cand_type    best_ff;
   logic        accept, load_ok, clear_set, walk_done;
   logic [21:0] comp_sum;
   logic [20:0] comp, tat;
   job_type     new_job;

   assign busy      = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign load_ok   = accept && (count_ff < 7'(MAX_PROCS));

   assign new_job.arrival = req_arrival_time;
   assign new_job.burst   = req_burst_time;
   assign new_job.prio    = req_priority_req;
   assign new_job.num     = count_ff + 7'd1;

   // Feed an empty token into cell 0 every cycle.
   assign chain[0] = '0;

   // Row of job cells; the token moves one cell per cycle.
   for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
      nps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (load_ok && count_ff == 7'(g)),
         .load_job (new_job),
         .clear    (clear_set),
         .mark     (state_ff == ST_EMIT),
         .mark_num (best_ff.num),
         .now      (now_ff),
         .hi_first (hi_ff),
         .cand_i   (chain[g]),
         .cand_o   (chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) hi_ff <= 1'b0;
      else if (csr_valid && csr_ready) hi_ff <= csr_high_number_first;
   end

   // The token at the row's end is complete once it has passed every cell
   // with time and done flags held.
   assign walk_done = (walk_ff == 7'(MAX_PROCS));

   // Completion with saturation; hold the pick in best_ff.
   assign comp_sum = {1'b0, now_ff} + 22'(best_ff.burst);
   assign comp     = comp_sum[21] ? TIME_MAX : comp_sum[20:0];
   assign tat      = comp - 21'(best_ff.arrival);
   assign clear_set = (state_ff == ST_EMIT) && (left_ff == 7'd1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_PICK && walk_done) best_ff <= chain[MAX_PROCS];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      left_in  = left_ff;
      walk_in  = walk_ff;
      now_in   = now_ff;
      case (state_ff)
         ST_LOAD: begin
            walk_in = '0;
            if (load_ok) count_in = count_ff + 7'd1;
            if (accept && req_last_process) begin
               state_in = ST_PICK;
               left_in  = load_ok ? count_ff + 7'd1 : count_ff;
               now_in   = '0;
            end
         end
         ST_PICK: begin
            if (!walk_done) walk_in = walk_ff + 7'd1;
            else if (chain[MAX_PROCS].found) state_in = ST_EMIT;
            else begin
               // Nothing ready: jump time to the earliest pending arrival
               // and walk the row again.
               now_in  = 21'(chain[MAX_PROCS].next_arr);
               walk_in = '0;
            end
         end
         ST_EMIT: begin
            now_in  = comp;
            left_in = left_ff - 7'd1;
            walk_in = '0;
            if (left_ff == 7'd1) begin
               state_in = ST_LOAD;
               count_in = '0;
               now_in   = '0;
            end else state_in = ST_PICK;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         left_ff  <= '0;
         walk_ff  <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         walk_ff  <= walk_in;
         now_ff   <= now_in;
      end
   end

   // Result beat is combinational off best_ff during the emit cycle.
   assign rsp_valid           = (state_ff == ST_EMIT);
   assign rsp_process_number  = best_ff.num;
   assign rsp_completion_time = comp;
   assign rsp_turnaround_time = tat;
   assign rsp_waiting_time    = (tat >= 21'(best_ff.burst)) ?
                                tat - 21'(best_ff.burst) : '0;
   assign rsp_last_result     = (left_ff == 7'd1);

   // A result beat only while busy.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");
   // Loaded count never exceeds the row length.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(MAX_PROCS)) else $error("count overflow");
   // Emit is always followed by a pick or a return to load.
   a_emit_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (state_ff == ST_PICK || state_ff == ST_LOAD))
      else $error("bad state after emit");
endmodule

### tb/tb_top.sv
// Self-checking bench for the non-preemptive priority scheduler.
// Loads job sets, predicts the schedule in a local model and compares
// each result beat. Depends on nps_pkg and nonpreemptive_priority_scheduler.
module tb_top;
   import nps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS = 16;

   typedef struct {
      logic [NUM_W-1:0]  num;
      logic [TIME_W-1:0] comp;
      logic [TIME_W-1:0] tat;
      logic [TIME_W-1:0] wt;
      logic              last;
   } sched_beat_type;

   // One directed row: job fields plus an optional typed-in expectation.
   typedef struct {
      logic [ARR_W-1:0]  arr;
      logic [BUR_W-1:0]  bur;
      logic [PRI_W-1:0]  pri;
      logic              last;
      bit                pinned;
      sched_beat_type    pin;
   } job_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_burst_time = '0;
   logic [7:0]  req_priority_req = '0;
   logic        req_last_process = 1'b0;
   logic        rsp_valid;
   logic [6:0]  rsp_process_number;
   logic [20:0] rsp_completion_time, rsp_turnaround_time, rsp_waiting_time;
   logic        rsp_last_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_high_number_first = 1'b0;

   nonpreemptive_priority_scheduler #(.MAX_PROCS(SLOTS)) uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: loaded jobs of the open set and the polarity bit.
   logic [ARR_W-1:0] job_arr [SLOTS];
   logic [BUR_W-1:0] job_bur [SLOTS];
   logic [PRI_W-1:0] job_pri [SLOTS];
   int unsigned      job_cnt = 0;
   bit               hi_first = 0;

   sched_beat_type schedule_q [$];
   int unsigned errors = 0, beats_seen = 0, sets_done = 0, jobs_sent = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic bit wins(input int a, input int b);
      if (job_pri[a] != job_pri[b])
         return hi_first ? job_pri[a] > job_pri[b] : job_pri[a] < job_pri[b];
      return job_arr[a] < job_arr[b];
   endfunction

   // Run the loaded set to completion and queue one beat per job.
   task automatic schedule_set();
      bit done [SLOTS];
      longint clk_now;
      longint comp, tat;
      int best;
      bit have;
      longint next_arr;
      sched_beat_type b;
      clk_now = 0;
      foreach (done[i]) done[i] = 0;
      for (int p = 0; p < job_cnt; p++) begin
         best = -1;
         for (int i = 0; i < job_cnt; i++)
            if (!done[i] && job_arr[i] <= clk_now && (best < 0 || wins(i, best))) best = i;
         if (best < 0) begin
            have = 0;
            next_arr = 0;
            for (int i = 0; i < job_cnt; i++)
               if (!done[i] && (!have || job_arr[i] < next_arr)) begin
                  next_arr = job_arr[i];
                  have = 1;
               end
            clk_now = next_arr;
            for (int i = 0; i < job_cnt; i++)
               if (!done[i] && job_arr[i] <= clk_now && (best < 0 || wins(i, best))) best = i;
         end
         comp = clk_now + job_bur[best];
         if (comp > TIME_MAX) comp = TIME_MAX;
         tat = comp - job_arr[best];
         b.num  = 7'(best + 1);
         b.comp = 21'(comp);
         b.tat  = 21'(tat);
         b.wt   = (tat >= job_bur[best]) ? 21'(tat - job_bur[best]) : 21'd0;
         b.last = (p + 1 == job_cnt);
         done[best] = 1;
         clk_now = comp;
         schedule_q.push_back(b);
      end
      job_cnt = 0;
   endtask

   // Accept one job into the predictor; drop it when the table is full.
   task automatic take_job(input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] bu,
                           input logic [PRI_W-1:0] pr, input logic lst);
      if (job_cnt < SLOTS) begin
         job_arr[job_cnt] = a;
         job_bur[job_cnt] = bu;
         job_pri[job_cnt] = pr;
         job_cnt++;
      end
      if (lst) schedule_set();
   endtask

   // Drive one beat and hold it until start meets busy low.
   task automatic send_job(input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] bu,
                           input logic [PRI_W-1:0] pr, input logic lst);
      req_arrival_time <= a;
      req_burst_time   <= bu;
      req_priority_req <= pr;
      req_last_process <= lst;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      take_job(a, bu, pr, lst);
      jobs_sent++;
      @(negedge clock);
   endtask

   // Random inter-beat gap; bursts of back-to-back beats in between.
   int unsigned burst_left = 0;
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         start <= 1'b0;
         if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      burst_left--;
   endtask

   // Wait out the last set, then write the polarity bit.
   task automatic set_polarity(input bit v);
      start <= 1'b0;
      while (schedule_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_high_number_first <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      hi_first = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Compare every result beat with the oldest prediction.
   sched_beat_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         beats_seen++;
         if (schedule_q.size() == 0) begin
            report("unexpected beat, job", rsp_process_number, 0);
         end else begin
            want = schedule_q.pop_front();
            if (rsp_process_number !== want.num)
               report("process_number", rsp_process_number, want.num);
            if (rsp_completion_time !== want.comp)
               report("completion_time", rsp_completion_time, want.comp);
            if (rsp_turnaround_time !== want.tat)
               report("turnaround_time", rsp_turnaround_time, want.tat);
            if (rsp_waiting_time !== want.wt)
               report("waiting_time", rsp_waiting_time, want.wt);
            if (rsp_last_result !== want.last)
               report("last_result", rsp_last_result, want.last);
            if (want.last) sets_done++;
         end
      end
   end

   // Directed rows: single jobs with pinned results, ties, idle jumps and an
   // overfull set.
   job_row_type rows [$];
   function automatic job_row_type mk(input int a, input int bu, input int pr, input bit l,
                                      input bit pn = 0, input int n = 0, input int c = 0,
                                      input int t = 0, input int w = 0);
      job_row_type r;
      r.arr = 16'(a); r.bur = 16'(bu); r.pri = 8'(pr); r.last = l; r.pinned = pn;
      r.pin.num = 7'(n); r.pin.comp = 21'(c); r.pin.tat = 21'(t); r.pin.wt = 21'(w);
      r.pin.last = l;
      return r;
   endfunction

   initial begin
      int unsigned set_len, fed;
      sched_beat_type pinned_q [$];
      sched_beat_type pin_want;
      rows.push_back(mk(0, 0, 0, 1, 1, 1, 0, 0, 0));
      rows.push_back(mk(16'hFFFF, 16'hFFFF, 8'hFF, 1, 1, 1, 131070, 65535, 0));
      rows.push_back(mk(5, 3, 2, 1, 1, 1, 8, 3, 0));
      // ties on priority, then on arrival, then on job number
      rows.push_back(mk(0, 4, 7, 0));
      rows.push_back(mk(0, 2, 7, 0));
      rows.push_back(mk(1, 1, 3, 0));
      rows.push_back(mk(100, 5, 0, 1));
      // overfull set: 17 beats, the last one dropped but still starts the run
      for (int i = 0; i < 17; i++)
         rows.push_back(mk(16'hFFFF - i, 16'hFFFF, i[7:0] ^ 8'hAA, i == 16));

      #1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int pass = 0; pass < 2; pass++) begin
         foreach (rows[i]) begin
            if (rows[i].pinned && pass == 0) pinned_q.push_back(rows[i].pin);
            send_job(rows[i].arr, rows[i].bur, rows[i].pri, rows[i].last);
            if (rows[i].pinned && pass == 0) begin
               // the predictor must agree with the value read off by hand
               pin_want = schedule_q[schedule_q.size() - 1];
               if (pin_want.comp !== pinned_q[0].comp || pin_want.wt !== pinned_q[0].wt ||
                   pin_want.tat !== pinned_q[0].tat || pin_want.num !== pinned_q[0].num)
                  report("pinned row completion", pin_want.comp, pinned_q[0].comp);
               void'(pinned_q.pop_front());
            end
         end
         set_polarity(pass == 0);
      end

      // Random sets, mostly short, occasionally full or overfull.
      fed = 0;
      while (fed < 272) begin
         if ($urandom_range(0, 9) == 0) set_polarity(1'($urandom_range(0, 1)));
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
         for (int j = 0; j < set_len; j++) begin
            pace();
            send_job(16'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                              : $urandom_range(0, 65535)),
                     16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 20)),
                     8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                     j == set_len - 1);
            fed++;
         end
      end
      set_polarity(0);

      $display("covered %0d jobs in %0d sets, %0d result beats", jobs_sent, sets_done,
               beats_seen);
      if (errors == 0 && schedule_q.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("tb_top: errors");
      $finish;
   end
endmodule
